FILE: hw/rtl/bca_pkg.sv
// Shared widths, codes and register indexes of the bitmap chunk allocator.
`timescale 1ns / 1ps

package bca_pkg;

    // Fixed field widths.
    localparam int ADDR_W        = 32;
    localparam int SIZE_W        = 17;
    localparam int COUNT_W       = 11;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;

    // Bitmap word geometry.
    localparam int MAP_WORD_BITS  = 32;
    localparam int MAP_WORD_SHIFT = 5;

    // Divider step counter width.
    localparam int DIV_STEP_W = $clog2(ADDR_W);

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_SIZE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_COUNT  = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [ADDR_W-1:0]  BASE_ADDRESS_RST = 32'd0;
    localparam logic [SIZE_W-1:0]  CHUNK_SIZE_RST   = 17'd64;
    localparam logic [COUNT_W-1:0] CHUNK_COUNT_RST  = 11'd1024;

    // Request kinds.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Response status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

endpackage

FILE: hw/rtl/bca_if.sv
// Valid/ready channel interfaces for allocator requests and responses.
`timescale 1ns / 1ps

interface bca_req_if;
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic [bca_pkg::ADDR_W-1:0] free_address;

    modport source (output valid, output req_type, output free_address, input ready);
    modport sink   (input valid, input req_type, input free_address, output ready);
endinterface

interface bca_rsp_if;
    logic                       valid;
    logic                       ready;
    bca_pkg::status_t           status;
    logic [bca_pkg::ADDR_W-1:0] chunk_address;

    modport source (output valid, output status, output chunk_address, input ready);
    modport sink   (input valid, input status, input chunk_address, output ready);
endinterface

FILE: hw/rtl/bca_div.sv
// Restoring divider, one quotient bit per cycle, for free-address offsets.
`timescale 1ns / 1ps

module bca_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bca_pkg::ADDR_W-1:0] dividend,
    input  logic [bca_pkg::SIZE_W-1:0] divisor,
    output logic                       done,
    output logic [bca_pkg::ADDR_W-1:0] quotient
);
    import bca_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_STEP_W-1:0] step_reg, step_next;
    logic [SIZE_W-1:0]     rem_reg, rem_next;
    logic [SIZE_W-1:0]     dsr_reg, dsr_next;
    logic [ADDR_W-1:0]     quo_reg, quo_next;

    logic [SIZE_W:0] trial;
    logic [SIZE_W:0] diff;
    logic            fits;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb
    begin
        trial = {rem_reg, quo_reg[ADDR_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        fits  = (trial >= {1'b0, dsr_reg});
    end

    // Step sequencing.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            dsr_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
            quo_next  = {quo_reg[ADDR_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == DIV_STEP_W'(ADDR_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: hw/rtl/bitmap_chunk_allocator.sv
// Top level of the bitmap chunk allocator: config, sequencer and bitmap memory.
//
//   Channel   Dir   Beat contents                    Handshake
//   -------   ---   ------------------------------   ------------------
//   cfg       in    cfg_index, cfg_data              cfg_wr_en
//   req       in    req_type, free_address           req.valid/req.ready
//   rsp       out   status, chunk_address            rsp.valid/rsp.ready
//
// One request is in work at a time. An allocate scans the bitmap, reading one bitmap word
// per cycle, then a multiply and an add form the address. A free waits on the 32-step
// divider that turns the offset into a chunk index, unless the address is out of range.
// req.ready rises with rsp.valid. After reset the bitmap is cleared one word per cycle
// while req.ready stays low. A finished response waits in an output register; the next
// request is taken while it waits, and only its own response stalls until rsp.ready
// frees that register.
`timescale 1ns / 1ps

module bitmap_chunk_allocator
#(
    parameter int MAX_CHUNKS = 1024
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [bca_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bca_pkg::CFG_DATA_W-1:0] cfg_data,
    bca_req_if.sink                        req,
    bca_rsp_if.source                      rsp
);
    import bca_pkg::*;

    localparam int MAP_WORDS = (MAX_CHUNKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int IDX_W     = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CNT_W     = $clog2(MAX_CHUNKS + 1);
    localparam int PROD_W    = IDX_W + SIZE_W;

    typedef enum logic [11:0] {
        S_CLEAR = 12'b0000_0000_0001,
        S_IDLE  = 12'b0000_0000_0010,
        S_SCAN  = 12'b0000_0000_0100,
        S_AMUL  = 12'b0000_0000_1000,
        S_AADD  = 12'b0000_0001_0000,
        S_FCHK  = 12'b0000_0010_0000,
        S_FCMP  = 12'b0000_0100_0000,
        S_FDIV  = 12'b0000_1000_0000,
        S_FRD   = 12'b0001_0000_0000,
        S_FWR   = 12'b0010_0000_0000,
        S_DONE  = 12'b0100_0000_0000,
        S_SPARE = 12'b1000_0000_0000
    } state_t;

    // Configuration registers.
    logic [ADDR_W-1:0]  base_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [COUNT_W-1:0] count_reg;

    // Sequencer state.
    state_t             state_reg, state_next;
    logic [WADDR_W-1:0] word_reg, word_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    status_t            res_status_reg, res_status_next;
    logic [ADDR_W-1:0]  res_addr_reg, res_addr_next;
    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    logic [ADDR_W-1:0]  out_addr_reg, out_addr_next;

    // Bitmap memory.
    logic [MAP_WORD_BITS-1:0] map_mem [MAP_WORDS];
    logic [MAP_WORD_BITS-1:0] mem_rdata_reg;
    logic                     mem_we;
    logic [WADDR_W-1:0]       mem_waddr;
    logic [MAP_WORD_BITS-1:0] mem_wdata;
    logic [WADDR_W-1:0]       rd_addr;

    // Derived configuration and datapath signals.
    logic [SIZE_W-1:0]         eff_size;
    logic [31:0]               eff_cnt32;
    logic [CNT_W-1:0]          eff_cnt;
    logic [IDX_W-1:0]          mul_a;
    logic [PROD_W-1:0]         mul_prod;
    logic [31:0]               rem32;
    logic [MAP_WORD_BITS-1:0]  avail;
    logic [MAP_WORD_SHIFT-1:0] free_pos;
    logic                      free_found;
    logic                      scan_last;
    logic [WADDR_W-1:0]        idx_word;
    logic [MAP_WORD_SHIFT-1:0] idx_bit;
    logic                      req_accept;
    logic                      out_free;
    logic                      div_start;
    logic                      div_done;
    logic [ADDR_W-1:0]         div_quo;

    // Configuration writes; indexes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= BASE_ADDRESS_RST;
            size_reg  <= CHUNK_SIZE_RST;
            count_reg <= CHUNK_COUNT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_BASE_ADDRESS: base_reg  <= cfg_data[ADDR_W-1:0];
                REG_CHUNK_SIZE:   size_reg  <= cfg_data[SIZE_W-1:0];
                REG_CHUNK_COUNT:  count_reg <= cfg_data[COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Effective size (zero acts as one) and count (clamped to capacity).
    always_comb
    begin
        eff_size  = (size_reg == '0) ? SIZE_W'(1) : size_reg;
        eff_cnt32 = (32'(count_reg) > 32'(MAX_CHUNKS)) ? 32'(MAX_CHUNKS) : 32'(count_reg);
        eff_cnt   = CNT_W'(eff_cnt32);
    end

    // Shared multiplier: chunk index times size, or last chunk index times size.
    always_comb
    begin
        mul_a    = (state_reg == S_FCHK) ? IDX_W'(eff_cnt32 - 32'd1) : idx_reg;
        mul_prod = PROD_W'(mul_a) * PROD_W'(eff_size);
    end

    // Lowest free chunk in the word under scan, limited to chunks below the count.
    always_comb
    begin
        rem32 = eff_cnt32 - (32'(word_reg) << MAP_WORD_SHIFT);
        for (int b = 0; b < MAP_WORD_BITS; b++)
        begin
            avail[b] = ~mem_rdata_reg[b] && (rem32 > 32'(b));
        end
        free_pos = '0;
        for (int b = MAP_WORD_BITS - 1; b >= 0; b--)
        begin
            if (avail[b])
            begin
                free_pos = MAP_WORD_SHIFT'(b);
            end
        end
        free_found = (avail != '0);
        scan_last  = (((32'(word_reg) + 32'd1) << MAP_WORD_SHIFT) >= eff_cnt32);
        idx_word   = WADDR_W'(32'(idx_reg) >> MAP_WORD_SHIFT);
        idx_bit    = MAP_WORD_SHIFT'(32'(idx_reg));
    end

    assign req_accept = req.valid && req.ready;
    assign out_free   = !out_valid_reg || rsp.ready;

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        word_next       = word_reg;
        idx_next        = idx_reg;
        addr_next       = addr_reg;
        prod_next       = prod_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        mem_we          = 1'b0;
        mem_waddr       = word_reg;
        mem_wdata       = '0;
        rd_addr         = word_reg;
        div_start       = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (word_reg == WADDR_W'(MAP_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    word_next = word_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                rd_addr = '0;
                if (req_accept)
                begin
                    word_next = '0;
                    addr_next = req.free_address;
                    state_next = (req.req_type == REQ_FREE) ? S_FCHK : S_SCAN;
                end
            end

            S_SCAN:
            begin
                // Read the next word while the current one is checked.
                rd_addr = word_reg + 1'b1;
                if (free_found)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = mem_rdata_reg | (MAP_WORD_BITS'(1) << free_pos);
                    idx_next   = IDX_W'({word_reg, free_pos});
                    state_next = S_AMUL;
                end
                else if (scan_last)
                begin
                    res_status_next = ST_FULL;
                    res_addr_next   = '0;
                    state_next      = S_DONE;
                end
                else
                begin
                    word_next = word_reg + 1'b1;
                end
            end

            S_AMUL:
            begin
                prod_next  = mul_prod;
                state_next = S_AADD;
            end

            S_AADD:
            begin
                res_status_next = ST_OK;
                res_addr_next   = base_reg + ADDR_W'(prod_reg);
                state_next      = S_DONE;
            end

            S_FCHK:
            begin
                if (eff_cnt == '0 || addr_reg < base_reg)
                begin
                    res_status_next = ST_RANGE;
                    res_addr_next   = '0;
                    state_next      = S_DONE;
                end
                else
                begin
                    addr_next  = addr_reg - base_reg;
                    prod_next  = mul_prod;
                    state_next = S_FCMP;
                end
            end

            S_FCMP:
            begin
                if (64'(addr_reg) > 64'(prod_reg))
                begin
                    res_status_next = ST_RANGE;
                    res_addr_next   = '0;
                    state_next      = S_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_FDIV;
                end
            end

            S_FDIV:
            begin
                if (div_done)
                begin
                    idx_next   = IDX_W'(div_quo);
                    state_next = S_FRD;
                end
            end

            S_FRD:
            begin
                rd_addr    = idx_word;
                state_next = S_FWR;
            end

            S_FWR:
            begin
                mem_we          = 1'b1;
                mem_waddr       = idx_word;
                mem_wdata       = mem_rdata_reg & ~(MAP_WORD_BITS'(1) << idx_bit);
                res_status_next = ST_OK;
                res_addr_next   = '0;
                state_next      = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_addr_next   = res_addr_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            word_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            word_reg      <= word_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        addr_reg       <= addr_next;
        prod_reg       <= prod_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
    end

    // Bitmap memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= map_mem[rd_addr];
    end

    // Offset to chunk index.
    bca_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (addr_reg),
        .divisor  (eff_size),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.chunk_address = out_addr_reg;

endmodule

FILE: verif/bitmap_chunk_allocator_tb.sv
// Self-checking testbench for the bitmap chunk allocator with a predictor scoreboard.
`timescale 1ns / 1ps

module bitmap_chunk_allocator_tb;

    import bca_pkg::*;

    localparam int MAX_CHUNKS = 1024;
    localparam int MAP_WORDS  = (MAX_CHUNKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int LONG_HOLD  = 400;
    localparam int SETTLE     = 60;
    localparam int N_PHASES   = 12;

    // Index past the last register; writes to it must leave the geometry alone.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        status_t           status;
        logic [ADDR_W-1:0] chunk_address;
    } alloc_rsp_t;

    // Shadow bitmap and geometry; predicts one response beat per request beat.
    class alloc_scoreboard;
        bit [MAP_WORD_BITS-1:0] usage [MAP_WORDS];
        logic [ADDR_W-1:0]      base_addr;
        logic [SIZE_W-1:0]      size_reg;
        logic [COUNT_W-1:0]     count_reg;
        alloc_rsp_t             expected_q [$];
        int                     errors;

        function new();
            foreach (usage[w])
                usage[w] = '0;
            base_addr = BASE_ADDRESS_RST;
            size_reg  = CHUNK_SIZE_RST;
            count_reg = CHUNK_COUNT_RST;
            errors    = 0;
        endfunction

        function int unsigned stride();
            return (size_reg == 0) ? 1 : size_reg;
        endfunction

        function int unsigned pool_chunks();
            return (count_reg > MAX_CHUNKS) ? MAX_CHUNKS : count_reg;
        endfunction

        function logic [ADDR_W-1:0] chunk_start(int unsigned idx);
            bit [63:0] wide;
            wide = {32'd0, base_addr} + 64'(idx) * 64'(stride());
            return wide[ADDR_W-1:0];
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_BASE_ADDRESS: base_addr = value;
                REG_CHUNK_SIZE:   size_reg  = value[SIZE_W-1:0];
                REG_CHUNK_COUNT:  count_reg = value[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        // Finds a chunk in use below the pool size, starting at a random index.
        function bit pick_used(output int unsigned idx);
            int unsigned n;
            int unsigned start;
            n = pool_chunks();
            idx = 0;
            if (n == 0)
                return 1'b0;
            start = $urandom_range(0, n - 1);
            for (int unsigned k = 0; k < n; k++) begin
                idx = (start + k) % n;
                if (usage[idx >> MAP_WORD_SHIFT][idx % MAP_WORD_BITS])
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        // Applies one accepted request to the shadow state and queues its response.
        function void note_request(logic kind, logic [ADDR_W-1:0] addr);
            alloc_rsp_t  rsp;
            int unsigned n;
            int unsigned sz;
            int unsigned idx;
            bit [63:0]   offset;
            bit [63:0]   last_start;
            n   = pool_chunks();
            sz  = stride();
            rsp.status        = ST_OK;
            rsp.chunk_address = '0;
            if (kind == REQ_ALLOC) begin
                // First fit: lowest clear bit below the pool size.
                idx = 0;
                while (idx < n && usage[idx >> MAP_WORD_SHIFT][idx % MAP_WORD_BITS])
                    idx++;
                if (idx < n) begin
                    usage[idx >> MAP_WORD_SHIFT][idx % MAP_WORD_BITS] = 1'b1;
                    rsp.chunk_address = chunk_start(idx);
                end else begin
                    rsp.status = ST_FULL;
                end
            end else if (n == 0 || addr < base_addr) begin
                rsp.status = ST_RANGE;
            end else begin
                // The bound is taken without wrapping; the offset is truncated to a chunk.
                offset     = 64'(addr - base_addr);
                last_start = 64'(n - 1) * 64'(sz);
                if (offset > last_start) begin
                    rsp.status = ST_RANGE;
                end else begin
                    idx = int'(offset / sz);
                    usage[idx >> MAP_WORD_SHIFT][idx % MAP_WORD_BITS] = 1'b0;
                end
            end
            expected_q.push_back(rsp);
        endfunction

        function void flag(string what, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
            errors++;
            if (errors <= 10)
                $display("MISMATCH %s: expected %h, got %h", what, want, got);
        endfunction

        // Compares one response beat with the oldest outstanding prediction.
        function void check_response(status_t status, logic [ADDR_W-1:0] chunk_address);
            alloc_rsp_t want;
            if (expected_q.size() == 0) begin
                flag("response with no request outstanding", '0, chunk_address);
                return;
            end
            want = expected_q.pop_front();
            if (status !== want.status)
                flag("status", 32'(want.status), 32'(status));
            if (chunk_address !== want.chunk_address)
                flag("chunk_address", want.chunk_address, chunk_address);
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        function void close_out();
            if (expected_q.size() != 0)
                flag("responses never seen", 32'(expected_q.size()), '0);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bca_req_if req_ch ();
    bca_rsp_if rsp_ch ();

    alloc_scoreboard sb = new();

    bit calm;
    bit hold_long;
    int stall_left;

    bitmap_chunk_allocator #(
        .MAX_CHUNKS (MAX_CHUNKS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Free-running clock, 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Response side: random stall bursts, one long hold-off on request.
    initial
    begin
        rsp_ch.ready = 1'b0;
        stall_left   = 0;
        forever
        begin
            @(negedge clk);
            if (hold_long) begin
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_long = 1'b0;
                rsp_ch.ready <= 1'b1;
            end else if (stall_left != 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 10);
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Every response beat goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.status, rsp_ch.chunk_address);
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        sb.set_register(idx, value);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Offers one request beat and waits until the block takes it.
    task automatic send_item(logic kind, logic [ADDR_W-1:0] addr);
        @(negedge clk);
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= kind;
        req_ch.free_address <= addr;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(kind, addr);
        if (!calm && $urandom_range(0, 3) == 0) begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(0, 10)) @(negedge clk);
        end
    endtask

    // Stops offering and waits for every outstanding response.
    task automatic drain();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    // Register value with random bits above the register width.
    function automatic logic [CFG_DATA_W-1:0] with_junk(int unsigned value, int width);
        return ($urandom() << width) | value;
    endfunction

    // Mostly allocates and frees of live chunks, plus out-of-range and random frees.
    task automatic run_phase(int n_items);
        int unsigned roll;
        int unsigned idx;
        int unsigned sz;
        for (int k = 0; k < n_items; k++) begin
            roll = $urandom_range(0, 99);
            sz   = sb.stride();
            if (roll < 55) begin
                send_item(REQ_ALLOC, $urandom());
            end else if (roll < 88 && sb.pick_used(idx)) begin
                if ($urandom_range(0, 1) == 0)
                    send_item(REQ_FREE, sb.chunk_start(idx));
                else
                    send_item(REQ_FREE, sb.chunk_start(idx) + $urandom_range(0, sz - 1));
            end else begin
                case ($urandom_range(0, 3))
                    0: send_item(REQ_FREE, $urandom());
                    1: send_item(REQ_FREE, sb.base_addr - $urandom_range(1, 4));
                    2: send_item(REQ_FREE, sb.chunk_start(sb.pool_chunks()) +
                                           $urandom_range(0, 3));
                    default: send_item(REQ_FREE, sb.chunk_start(sb.pool_chunks()) - 1);
                endcase
            end
        end
    endtask

    initial
    begin
        logic [ADDR_W-1:0] base_v;
        int unsigned       size_v;
        int unsigned       count_v;
        int                n_items;

        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_index           = REG_BASE_ADDRESS;
        cfg_data            = '0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = REQ_ALLOC;
        req_ch.free_address = '0;
        calm                = 1'b0;
        hold_long           = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Reset geometry: 1024 chunks of 64 bytes from address 0.
        send_item(REQ_ALLOC, 32'hFFFF_FFFF);
        send_item(REQ_ALLOC, 32'h0000_0000);
        send_item(REQ_FREE, 32'd69);
        send_item(REQ_FREE, 32'd69);
        send_item(REQ_ALLOC, 32'h0000_0000);
        send_item(REQ_FREE, 32'hFFFF_FFFF);
        send_item(REQ_FREE, 32'd65535);
        send_item(REQ_FREE, 32'd65536);
        send_item(REQ_FREE, 32'd0);
        send_item(REQ_FREE, 32'd64);
        drain();

        // Pool running past the top of the address space, count above capacity.
        write_reg(REG_BASE_ADDRESS, 32'hFFFF_FFC0);
        write_reg(REG_CHUNK_SIZE, 32'h0001_0000);
        write_reg(REG_CHUNK_COUNT, 32'd2047);
        send_item(REQ_ALLOC, 32'h0000_0000);
        send_item(REQ_ALLOC, 32'h0000_0000);
        send_item(REQ_FREE, 32'h0000_FFC0);
        send_item(REQ_FREE, 32'hFFFF_FFC0);
        send_item(REQ_FREE, 32'hFFFF_FFFF);
        send_item(REQ_FREE, 32'hFFFF_FFBF);
        drain();

        // Zero chunk size and zero chunk count.
        write_reg(REG_CHUNK_SIZE, 32'd0);
        write_reg(REG_CHUNK_COUNT, 32'd0);
        send_item(REQ_ALLOC, 32'h0000_0000);
        send_item(REQ_FREE, 32'hFFFF_FFC0);
        drain();

        // A single one-byte chunk.
        write_reg(REG_BASE_ADDRESS, 32'h0000_0100);
        write_reg(REG_CHUNK_COUNT, 32'd1);
        send_item(REQ_ALLOC, 32'h0000_0000);
        send_item(REQ_ALLOC, 32'h0000_0000);
        send_item(REQ_FREE, 32'h0000_0101);
        send_item(REQ_FREE, 32'h0000_0100);
        drain();

        // A write past the last register must change nothing.
        write_reg(REG_UNUSED, $urandom());
        send_item(REQ_ALLOC, 32'h0000_0000);
        drain();

        // Random phases, each with its own geometry.
        for (int p = 0; p < N_PHASES; p++) begin
            n_items = 128;
            case (p)
                0:  begin base_v = '0;            size_v = 64;      count_v = 1024; end
                1:  begin base_v = $urandom();    size_v = 1;       count_v = 16;   end
                2:  begin base_v = 32'hFFFF_FFFF; size_v = 0;       count_v = 8;    end
                3:  begin base_v = $urandom();    size_v = 65536;   count_v = 2047; end
                4:  begin
                    base_v  = $urandom();
                    size_v  = $urandom_range(1, 200);
                    count_v = $urandom_range(1, 40);
                end
                5:  begin base_v = '0;            size_v = 17'h1FFFF; count_v = 1;  end
                6:  begin
                    base_v  = $urandom();
                    size_v  = $urandom_range(1, 4096);
                    count_v = 0;
                    n_items = 30;
                end
                7:  begin
                    base_v  = $urandom() & 32'hFFFF_F000;
                    size_v  = $urandom_range(1, 65536);
                    count_v = $urandom_range(1, 64);
                end
                8:  begin base_v = $urandom(); size_v = 64; count_v = $urandom_range(100, 300); end
                9:  begin base_v = 32'hFFFF_0000; size_v = $urandom_range(1, 1024); count_v = 1024; end
                10: begin
                    base_v  = $urandom();
                    size_v  = $urandom_range(1, 65536);
                    count_v = $urandom_range(1, 1024);
                end
                default: begin
                    base_v  = $urandom();
                    size_v  = $urandom_range(1, 256);
                    count_v = $urandom_range(1, 48);
                end
            endcase
            write_reg(REG_UNUSED, $urandom());
            write_reg(REG_BASE_ADDRESS, base_v);
            write_reg(REG_CHUNK_SIZE, with_junk(size_v, SIZE_W));
            write_reg(REG_CHUNK_COUNT, with_junk(count_v, COUNT_W));
            calm = (p == 5 || p == N_PHASES - 1);
            // The first phase fills the output side so the request side backs up.
            if (p == 0)
                hold_long = 1'b1;
            run_phase(n_items);
            drain();
        end

        repeat (SETTLE) @(posedge clk);
        sb.close_out();
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/bca_pkg.sv
hw/rtl/bca_if.sv
hw/rtl/bca_div.sv
hw/rtl/bitmap_chunk_allocator.sv
verif/bitmap_chunk_allocator_tb.sv
